// File: sv/cmse_pkg.sv
// Shared constants, types and hash helpers for the count-min sketch engine.
`default_nettype none
package cmse_pkg;

    localparam int unsigned ROWS_DEF        = 4;
    localparam int unsigned MAX_COLUMNS_DEF = 1024;

    localparam int unsigned HASH_W  = 64;
    localparam int unsigned COUNT_W = 64;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned IN_TDATA_W = 80;

    localparam logic [63:0] SEED_MULT = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1b3;

    localparam logic CMD_UPDATE   = 1'b0;
    localparam logic CMD_ESTIMATE = 1'b1;

    typedef logic [HASH_W-1:0] t_hash;

    // Offset basis of a row, XORed with that row's golden-ratio seed.
    function automatic t_hash seeded_basis(input int unsigned row);
        logic [63:0] mult;
        mult = SEED_MULT * 64'(row + 1);
        return FNV_BASIS ^ mult;
    endfunction

    // One FNV-1a step. The prime is 2^40 + 0x1b3, so the product is a shift plus
    // a narrow multiply.
    function automatic t_hash fnv_step(input t_hash h, input logic [7:0] b);
        t_hash x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x * {55'd0, FNV_PRIME_LOW});
    endfunction

endpackage
`default_nettype wire

// File: sv/count_min_sketch_engine_core.sv
// Top level of the count-min sketch engine: ports, config register and wiring.
// Flow: a key byte is hashed in the cycle it is accepted; a key's last byte queues a
// job, and the back end runs the column remainder, then a read and an update per row,
// then loads the result register; it takes the next key only when done with the last.
// Throughput: one byte per cycle while the queue has room and the store is not cleared.
// Reset: synchronous, active low; the counter store is then cleared, accepting nothing.
`default_nettype none
module count_min_sketch_engine_core
    import cmse_pkg::*;
#(
    parameter int unsigned ROWS        = ROWS_DEF,
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]      i_cfg_wr_data,   // column_count
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,    // key_byte[7:0], byte_present[8], count[72:9]
    input  wire logic                  s_axis_tlast,    // key_last
    input  wire logic                  s_axis_tuser,    // cmd
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [COUNT_W-1:0]         m_axis_tdata,    // estimate[63:0]
    output logic                       m_axis_tuser     // was_update
);

    localparam int unsigned JOB_W = ROWS * HASH_W + COUNT_W + 1;

    logic [CFG_W-1:0] r_cfg_cols;
    logic [CFG_W-1:0] cols;
    logic             accept;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic             clear_busy;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;

    // The column count register resets to 1024 and is used saturated to the
    // range one through MAX_COLUMNS.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_W'(1024);
        end else if (i_cfg_wr_en) begin
            r_cfg_cols <= i_cfg_wr_data;
        end
    end

    always_comb begin
        cols = r_cfg_cols;
        if (r_cfg_cols == '0) begin
            cols = CFG_W'(1);
        end else if (32'(r_cfg_cols) > MAX_COLUMNS) begin
            cols = CFG_W'(MAX_COLUMNS);
        end
    end

    // The front takes bytes whenever the queue has room and the store is not
    // being cleared; only the last byte of a key occupies a queue entry.
    assign s_axis_tready = !q_full && !clear_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cmse_front #(
        .ROWS (ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_cmd          (s_axis_tuser),
        .i_key_byte     (s_axis_tdata[7:0]),
        .i_byte_present (s_axis_tdata[8]),
        .i_key_last     (s_axis_tlast),
        .i_count        (s_axis_tdata[72:9]),
        .o_push         (push),
        .o_job          (job_in)
    );

    cmse_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (job_out)
    );

    // The back end owns the counter store and the result register, so a
    // finished result can wait while new keys are hashed and queued.
    cmse_back #(
        .ROWS        (ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cols       (cols),
        .i_job_valid  (q_valid),
        .i_job        (job_out),
        .o_pop        (pop),
        .o_clear_busy (clear_busy),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_estimate   (m_axis_tdata),
        .o_was_update (m_axis_tuser)
    );

endmodule
`default_nettype wire

// File: sv/cmse_queue.sv
// Two-entry queue that parts the hashing front from the counter back end.
`default_nettype none
module cmse_queue
    import cmse_pkg::*;
#(
    parameter int unsigned WIDTH = 321
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule
`default_nettype wire

// File: sv/cmse_front.sv
// Front end: accepts key bytes and runs the per-row FNV-1a hashes.
`default_nettype none
module cmse_front
    import cmse_pkg::*;
#(
    parameter int unsigned ROWS = ROWS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic                     i_cmd,
    input  wire logic [7:0]               i_key_byte,
    input  wire logic                     i_byte_present,
    input  wire logic                     i_key_last,
    input  wire logic [COUNT_W-1:0]       i_count,
    output logic                          o_push,
    output logic [ROWS*HASH_W+COUNT_W:0]  o_job
);

    t_hash r_hash [ROWS];
    t_hash n_hash [ROWS];

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            n_hash[r] = i_byte_present ? fnv_step(r_hash[r], i_key_byte) : r_hash[r];
            o_job[COUNT_W + 1 + r*HASH_W +: HASH_W] = n_hash[r];
        end
        o_job[COUNT_W]     = i_cmd;
        o_job[COUNT_W-1:0] = i_count;
    end

    assign o_push = i_accept && i_key_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_hash[r] <= seeded_basis(r);
            end
        end else if (i_accept) begin
            for (int r = 0; r < ROWS; r++) begin
                r_hash[r] <= i_key_last ? seeded_basis(r) : n_hash[r];
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/cmse_back.sv
// Back end: column remainder, counter store read-modify-write and result register.
`default_nettype none
module cmse_back
    import cmse_pkg::*;
#(
    parameter int unsigned ROWS        = ROWS_DEF,
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [CFG_W-1:0]              i_cols,
    input  wire logic                          i_job_valid,
    input  wire logic [ROWS*HASH_W+COUNT_W:0]  i_job,
    output logic                               o_pop,
    output logic                               o_clear_busy,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [COUNT_W-1:0]                 o_estimate,
    output logic                               o_was_update
);

    localparam int unsigned DEPTH = ROWS * MAX_COLUMNS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]         r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [3:0]         r_step;
    logic [RIW-1:0]     r_row;
    t_hash              r_h   [ROWS];
    logic [CFG_W-1:0]   r_rem [ROWS];
    logic [CFG_W-1:0]   n_rem [ROWS];
    logic               r_cmd;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_best;
    logic [COUNT_W-1:0] r_rd;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_est;
    logic               r_out_upd;

    logic [63:0]        mem [DEPTH];
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [63:0]        wr_data;
    logic               mem_we;
    logic               out_load;

    // Four restoring-remainder steps per cycle on each row, MSB first.
    always_comb begin
        logic [CFG_W:0] t;
        for (int r = 0; r < ROWS; r++) begin
            n_rem[r] = r_rem[r];
            for (int k = 0; k < 4; k++) begin
                t = {n_rem[r], r_h[r][HASH_W-1-k]};
                if (t >= {1'b0, i_cols}) begin
                    t = t - {1'b0, i_cols};
                end
                n_rem[r] = t[CFG_W-1:0];
            end
        end
    end

    assign rd_addr = AW'(AW'(r_row) * AW'(MAX_COLUMNS) + AW'(r_rem[r_row]));
    assign mem_we  = (r_state == S_CLEAR) || ((r_state == S_UPD) && (r_cmd == CMD_UPDATE));
    assign wr_addr = (r_state == S_CLEAR) ? r_clr_addr : rd_addr;
    assign wr_data = (r_state == S_CLEAR) ? 64'd0 : (r_rd + r_count);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    assign o_pop        = (r_state == S_IDLE) && i_job_valid;
    assign o_clear_busy = (r_state == S_CLEAR);
    assign out_load     = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_step      <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_row   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_row == RIW'(ROWS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int r = 0; r < ROWS; r++) begin
                r_h[r]   <= i_job[COUNT_W + 1 + r*HASH_W +: HASH_W];
                r_rem[r] <= '0;
            end
            r_cmd   <= i_job[COUNT_W];
            r_count <= i_job[COUNT_W-1:0];
            r_best  <= '1;
        end else if (r_state == S_DIV) begin
            for (int r = 0; r < ROWS; r++) begin
                r_h[r]   <= r_h[r] << 4;
                r_rem[r] <= n_rem[r];
            end
        end else if ((r_state == S_UPD) && (r_rd < r_best)) begin
            r_best <= r_rd;
        end
        if (out_load) begin
            r_out_est <= (r_cmd == CMD_UPDATE) ? '0 : r_best;
            r_out_upd <= (r_cmd == CMD_UPDATE);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_estimate   = r_out_est;
    assign o_was_update = r_out_upd;

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_UPD))
        else $error("counter store written outside clear or update");
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the output step");
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("job taken during clearing pass");

endmodule
`default_nettype wire
